[rtl/core/dtsp_pkg.sv]
// ----------------------------------------------------------------------------
// dtsp_pkg
// Shared widths, register indexes and reset values for the distance-based
// trapezoid speed profile core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsp_pkg;

    // input distance fields, two's complement
    localparam int FIELD_W   = 21;
    // magnitude of a non-negative distance
    localparam int DIST_W    = FIELD_W - 1;
    // configuration registers and speed result
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // radicand: start^2 + 2*accel*dist fits in 38 bits
    localparam int RAD_W     = 38;
    localparam int ROOT_W    = RAD_W / 2;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_SPEED  = 2'd0,
        REG_ACCEL_RATE   = 2'd1,
        REG_DECEL_RATE   = 2'd2,
        REG_CRUISE_SPEED = 2'd3
    } cfg_reg_t;

    // register reset values
    localparam logic [REG_W-1:0] START_SPEED_RST  = 16'd100;
    localparam logic [REG_W-1:0] ACCEL_RATE_RST   = 16'd500;
    localparam logic [REG_W-1:0] DECEL_RATE_RST   = 16'd500;
    localparam logic [REG_W-1:0] CRUISE_SPEED_RST = 16'd500;

endpackage

`default_nettype wire

[rtl/core/distance_trapezoid_speed_profile_core.sv]
// ----------------------------------------------------------------------------
// distance_trapezoid_speed_profile_core
// Feed-forward speed from travelled and target distance: the minimum of the
// cruise ceiling, the ramp-up limit sqrt(start^2 + 2*accel*dist) and the
// ramp-down limit sqrt(2*decel*remaining), zero when arrived or invalid.
//
// Usage:
//   - a beat enters when start is high; busy stays low, so one beat can
//     enter every clock cycle
//   - each beat gives exactly one result on speed_cmd, marked by a one-cycle
//     done strobe, in the order the beats entered
//   - throughput is one beat per cycle, set by the two pipelined square-root
//     units that each resolve SQRT_BITS_PER_STAGE bits a stage; a beat passes
//     stages a, b, c, the square-root stages and the output register
//   - the receiver cannot stall; results are shown once and not held
//   - configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
//     edge; the user must make them only while no beat is in flight; not enforced
//   - reset clears the pipeline valid bits and loads the default registers:
//     start 100 mm/s, accel 500 mm/s^2, decel 500 mm/s^2, cruise 500 mm/s
// ----------------------------------------------------------------------------
`default_nettype none

module distance_trapezoid_speed_profile_core #(
    parameter int SQRT_BITS_PER_STAGE = 3
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // command channel
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [dtsp_pkg::FIELD_W-1:0] travelled_mm,
    input  wire logic signed [dtsp_pkg::FIELD_W-1:0] goal_mm,
    // result channel
    output logic                                     done,
    output logic [dtsp_pkg::REG_W-1:0]               speed_cmd,
    // configuration port
    input  wire logic                                cfg_we,
    input  wire logic [dtsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dtsp_pkg::REG_W-1:0]          cfg_data
);

    localparam int DIST_W = dtsp_pkg::DIST_W;
    localparam int REG_W  = dtsp_pkg::REG_W;
    localparam int RAD_W  = dtsp_pkg::RAD_W;
    localparam int ROOT_W = dtsp_pkg::ROOT_W;
    localparam int SQ_W   = 2 * REG_W;
    localparam int PROD_W = REG_W + DIST_W;

    // configuration registers
    logic [REG_W-1:0] start_speed_reg;
    logic [REG_W-1:0] accel_rate_reg;
    logic [REG_W-1:0] decel_rate_reg;
    logic [REG_W-1:0] cruise_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_speed_reg  <= dtsp_pkg::START_SPEED_RST;
            accel_rate_reg   <= dtsp_pkg::ACCEL_RATE_RST;
            decel_rate_reg   <= dtsp_pkg::DECEL_RATE_RST;
            cruise_speed_reg <= dtsp_pkg::CRUISE_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtsp_pkg::REG_START_SPEED:  start_speed_reg  <= cfg_data;
                dtsp_pkg::REG_ACCEL_RATE:   accel_rate_reg   <= cfg_data;
                dtsp_pkg::REG_DECEL_RATE:   decel_rate_reg   <= cfg_data;
                dtsp_pkg::REG_CRUISE_SPEED: cruise_speed_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // fully pipelined, never refuses a beat
    assign busy = 1'b0;

    // ---------------- stage a: clamp and remaining distance ----------------
    logic              valid_a_reg, valid_a_next;
    logic [DIST_W-1:0] dist_a_reg,  dist_a_next;
    logic [DIST_W-1:0] rem_a_reg,   rem_a_next;

    always_comb
    begin
        logic              goal_pos;
        logic              live;
        logic [DIST_W-1:0] goal_mag;
        goal_mag    = goal_mm[DIST_W-1:0];
        goal_pos    = !goal_mm[DIST_W] && (goal_mag != '0);
        // negative travel counts as zero
        dist_a_next = travelled_mm[DIST_W] ? '0 : travelled_mm[DIST_W-1:0];
        live        = goal_pos && (dist_a_next < goal_mag);
        // a zero remaining distance forces the ramp-down limit, and so the result, to zero
        rem_a_next  = live ? (goal_mag - dist_a_next) : '0;
        valid_a_next = start && !busy;
    end

    // ---------------- stage b: products ----------------
    logic              valid_b_reg;
    logic [SQ_W-1:0]   sq_b_reg,  sq_b_next;
    logic [PROD_W-1:0] acc_b_reg, acc_b_next;
    logic [PROD_W-1:0] dec_b_reg, dec_b_next;

    always_comb
    begin
        sq_b_next  = SQ_W'(start_speed_reg) * SQ_W'(start_speed_reg);
        acc_b_next = PROD_W'(accel_rate_reg) * PROD_W'(dist_a_reg);
        dec_b_next = PROD_W'(decel_rate_reg) * PROD_W'(rem_a_reg);
    end

    // ---------------- stage c: radicands ----------------
    logic             valid_c_reg;
    logic [RAD_W-1:0] rad_acc_c_reg, rad_acc_c_next;
    logic [RAD_W-1:0] rad_dec_c_reg, rad_dec_c_next;

    always_comb
    begin
        rad_acc_c_next = RAD_W'(sq_b_reg) + RAD_W'({acc_b_reg, 1'b0});
        rad_dec_c_next = RAD_W'({dec_b_reg, 1'b0});
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        dist_a_reg    <= dist_a_next;
        rem_a_reg     <= rem_a_next;
        sq_b_reg      <= sq_b_next;
        acc_b_reg     <= acc_b_next;
        dec_b_reg     <= dec_b_next;
        rad_acc_c_reg <= rad_acc_c_next;
        rad_dec_c_reg <= rad_dec_c_next;
    end

    // ---------------- square roots ----------------
    logic              acc_root_valid;
    logic              dec_root_valid;
    logic [ROOT_W-1:0] v_acc;
    logic [ROOT_W-1:0] v_dec;

    dtsp_isqrt #(
        .RAD_W          (RAD_W),
        .BITS_PER_STAGE (SQRT_BITS_PER_STAGE)
    ) u_sqrt_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_c_reg),
        .radicand  (rad_acc_c_reg),
        .out_valid (acc_root_valid),
        .root      (v_acc)
    );

    dtsp_isqrt #(
        .RAD_W          (RAD_W),
        .BITS_PER_STAGE (SQRT_BITS_PER_STAGE)
    ) u_sqrt_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_c_reg),
        .radicand  (rad_dec_c_reg),
        .out_valid (dec_root_valid),
        .root      (v_dec)
    );

    // ---------------- output stage: minimum against cruise ----------------
    logic             done_reg,  done_next;
    logic [REG_W-1:0] speed_reg, speed_next;

    always_comb
    begin
        speed_next = cruise_speed_reg;
        if (v_acc < ROOT_W'(speed_next))
        begin
            speed_next = v_acc[REG_W-1:0];
        end
        if (v_dec < ROOT_W'(speed_next))
        begin
            speed_next = v_dec[REG_W-1:0];
        end
        done_next = acc_root_valid && dec_root_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
    end

    assign done      = done_reg;
    assign speed_cmd = speed_reg;

endmodule

`default_nettype wire

[rtl/core/dtsp_isqrt.sv]
// ----------------------------------------------------------------------------
// dtsp_isqrt
// Pipelined floored integer square root, digit by digit. Each register stage
// resolves BITS_PER_STAGE root bits (the last stage the rest); a new radicand can enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsp_isqrt #(
    parameter int RAD_W          = 38,
    parameter int BITS_PER_STAGE = 3
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [RAD_W-1:0]     radicand,
    output logic                      out_valid,
    output logic [RAD_W/2-1:0]        root
);

    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int NSTAGE  = (ROOT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    logic [RAD_W-1:0]  x_reg     [NSTAGE];
    logic [REM_W-1:0]  r_reg     [NSTAGE];
    logic [ROOT_W-1:0] q_reg     [NSTAGE];
    logic              valid_reg [NSTAGE];

    logic [RAD_W-1:0]  x_next     [NSTAGE];
    logic [REM_W-1:0]  r_next     [NSTAGE];
    logic [ROOT_W-1:0] q_next     [NSTAGE];
    logic              valid_next [NSTAGE];

    genvar s;
    generate
        for (s = 0; s < NSTAGE; s++) begin : g_stage

            logic [RAD_W-1:0]  x_in;
            logic [REM_W-1:0]  r_in;
            logic [ROOT_W-1:0] q_in;
            logic              v_in;

            // stage input: ports for the first stage, previous stage otherwise
            if (s == 0) begin : g_first
                assign x_in = radicand;
                assign r_in = '0;
                assign q_in = '0;
                assign v_in = in_valid;
            end else begin : g_chain
                assign x_in = x_reg[s-1];
                assign r_in = r_reg[s-1];
                assign q_in = q_reg[s-1];
                assign v_in = valid_reg[s-1];
            end

            // resolve this stage's share of root bits
            always_comb
            begin
                logic [RAD_W-1:0]  x;
                logic [REM_W-1:0]  r;
                logic [REM_W-1:0]  trial;
                logic [ROOT_W-1:0] q;
                x = x_in;
                r = r_in;
                q = q_in;
                for (int k = 0; k < BITS_PER_STAGE; k++)
                begin
                    if (s * BITS_PER_STAGE + k < ROOT_W)
                    begin
                        r     = {r[ROOT_W-1:0], x[RAD_W-1:RAD_W-2]};
                        x     = {x[RAD_W-3:0], 2'b00};
                        trial = {q, 2'b01};
                        if (r >= trial)
                        begin
                            r = r - trial;
                            q = {q[ROOT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            q = {q[ROOT_W-2:0], 1'b0};
                        end
                    end
                end
                x_next[s]     = x;
                r_next[s]     = r;
                q_next[s]     = q;
                valid_next[s] = v_in;
            end

            // valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= valid_next[s];
                end
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                x_reg[s] <= x_next[s];
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
            end
        end
    endgenerate

    assign out_valid = valid_reg[NSTAGE-1];
    assign root      = q_reg[NSTAGE-1];

endmodule

`default_nettype wire
